/* hw/rtl/beat_sync_event_scheduler_defines.svh */
// Assertion helpers for the beat sync scheduler
`ifndef BEAT_SYNC_EVENT_SCHEDULER_DEFINES_SVH
`define BEAT_SYNC_EVENT_SCHEDULER_DEFINES_SVH

`define BSES_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");

`define BSES_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");

`endif

/* hw/rtl/bses_pkg.sv */
package bses_pkg;
  localparam int BeatBits = 48;
  localparam int TagBits = 16;
  typedef logic signed [BeatBits-1:0] beat_t;
  typedef logic [TagBits-1:0] tag_t;
  typedef enum logic [1:0] {
    FUNC_SYNC = 2'd0,
    FUNC_TICK = 2'd1,
    FUNC_RESCHED = 2'd2,
    FUNC_NONE = 2'd3
  } func_t;
  typedef enum logic [1:0] {
    KIND_ACCEPTED = 2'd0,
    KIND_FIRED = 2'd1,
    KIND_BAD_PERIOD = 2'd2,
    KIND_FULL = 2'd3
  } kind_t;
  localparam beat_t BeatMax = {1'b0, {(BeatBits-1){1'b1}}};
endpackage

/* hw/rtl/bses_target.sv */
module bses_target (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  bses_pkg::beat_t c,
  input  bses_pkg::beat_t p,
  input  bses_pkg::beat_t f,
  input  bses_pkg::beat_t g,
  output logic done,
  output bses_pkg::beat_t result
);
  import bses_pkg::*;

  typedef enum logic [2:0] {
    T_IDLE, T_DIV1, T_DIV2, T_GRID, T_STEP, T_CLAMP
  } tstate_t;

  localparam int W = BeatBits + 2;

  tstate_t state;
  logic [W-1:0] rem;
  logic [W-1:0] dvd;
  logic [W-1:0] dsr;
  logic [6:0] cnt;
  logic neg;
  logic signed [W-1:0] nb;
  logic signed [W-1:0] cw;
  logic signed [W-1:0] pw;
  logic [W-1:0] rem_shift;
  logic [W-1:0] rem_sub;
  logic signed [W-1:0] rs;

  assign rem_shift = {rem[W-2:0], dvd[W-1]};
  assign rem_sub = rem_shift - dsr;
  assign rs = neg ? -$signed(rem) : $signed(rem);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        T_IDLE: begin
          if (start) begin
            cw <= W'(c);
            pw <= W'(p);
            neg <= c[BeatBits-1];
            dvd <= c[BeatBits-1] ? W'(-W'(c)) : W'(c);
            dsr <= W'(p);
            rem <= '0;
            cnt <= 7'(W);
            if (p[BeatBits-1] || p == '0) begin
              result <= '0;
              done <= 1'b1;
            end else begin
              state <= T_DIV1;
            end
          end
        end
        T_DIV1, T_DIV2: begin
          if (cnt != '0) begin
            dvd <= {dvd[W-2:0], 1'b0};
            if (!rem_sub[W-1]) rem <= rem_sub;
            else rem <= rem_shift;
            cnt <= cnt - 7'd1;
          end else if (state == T_DIV1) begin
            if (rem == '0) begin
              result <= c;
              done <= 1'b1;
              state <= T_IDLE;
            end else begin
              neg <= (cw - W'(g)) < 0;
              dvd <= ((cw - W'(g)) < 0) ? W'(-(cw - W'(g))) : W'(cw - W'(g));
              rem <= '0;
              cnt <= 7'(W);
              state <= T_DIV2;
            end
          end else begin
            if (rs < 0) nb <= cw - (rs + pw) + pw + W'(f);
            else nb <= cw - rs + pw + W'(f);
            state <= T_GRID;
          end
        end
        T_GRID: begin
          if (nb <= cw) begin
            neg <= 1'b0;
            dvd <= W'(cw - nb);
            rem <= '0;
            cnt <= 7'(W);
            state <= T_STEP;
          end else begin
            state <= T_CLAMP;
          end
        end
        T_STEP: begin
          if (cnt != '0) begin
            dvd <= {dvd[W-2:0], 1'b0};
            if (!rem_sub[W-1]) rem <= rem_sub;
            else rem <= rem_shift;
            cnt <= cnt - 7'd1;
          end else begin
            nb <= cw + pw - $signed(rem);
            state <= T_CLAMP;
          end
        end
        T_CLAMP: begin
          if (nb < 0) result <= '0;
          else if (nb > W'(BeatMax)) result <= BeatMax;
          else result <= nb[BeatBits-1:0];
          done <= 1'b1;
          state <= T_IDLE;
        end
        default: state <= T_IDLE;
      endcase
    end
  end
endmodule

/* hw/rtl/beat_sync_event_scheduler.sv */
// Sync: its result waits on the target search, the longer path being when the grid needs stepping;
// a rejected sync gives its result in the cycle after it is taken.
// Tick: kept entries are compacted in place and each fired one is sent as a result; output stalls hold the walk.
// Reschedule: recomputes the target of every stored entry in turn, no result.
// Throughput: one request at a time; the next is taken after the last result is accepted, or after the walk if none.
// Reset: synchronous, clears current beat, fill count, state, output valid, last flag and the target start.
module beat_sync_event_scheduler #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] func,
  input  bses_pkg::beat_t position_beat,
  input  bses_pkg::beat_t period_beat,
  input  bses_pkg::beat_t offset_beat,
  input  bses_pkg::beat_t origin_beat,
  input  bses_pkg::tag_t tag,
  output logic out_valid,
  input  logic out_stall,
  output logic [1:0] kind,
  output bses_pkg::tag_t result_tag,
  output bses_pkg::beat_t target_beat,
  output logic last
);
  import bses_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int MaxFire = 16;

  typedef enum logic [2:0] {
    S_IDLE, S_SYNC, S_TICK, S_TICK_OUT, S_RES, S_RES_WAIT, S_OUT
  } state_t;

  state_t state;
  beat_t cur_beat;
  beat_t e_period [TABLE_DEPTH];
  beat_t e_offset [TABLE_DEPTH];
  beat_t e_origin [TABLE_DEPTH];
  beat_t e_target [TABLE_DEPTH];
  tag_t e_tag [TABLE_DEPTH];
  logic [CW-1:0] used;
  logic [CW-1:0] rd;
  logic [CW-1:0] wr;
  logic [4:0] fired;
  beat_t pos;
  beat_t per;
  beat_t off;
  beat_t org;
  tag_t tg;
  logic t_start;
  logic t_done;
  beat_t t_res;
  beat_t t_c;
  beat_t t_p;
  beat_t t_f;
  beat_t t_g;
  logic [IW-1:0] ri;
  logic [IW-1:0] wi;
  logic [IW-1:0] ui;
  logic hit;

  assign ri = rd[IW-1:0];
  assign wi = wr[IW-1:0];
  assign ui = used[IW-1:0];
  assign in_stall = (state != S_IDLE);
  assign hit = (rd < used) && (fired < 5'(MaxFire)) && (pos > e_target[ri]);

  bses_target u_target (
    .clk(clk), .rst(rst), .start(t_start), .c(t_c), .p(t_p), .f(t_f), .g(t_g),
    .done(t_done), .result(t_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cur_beat <= '0;
      used <= '0;
      out_valid <= 1'b0;
      t_start <= 1'b0;
      last <= 1'b0;
    end else begin
      t_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            pos <= position_beat;
            per <= period_beat;
            off <= offset_beat;
            org <= origin_beat;
            tg <= tag;
            rd <= '0;
            wr <= '0;
            fired <= '0;
            case (func)
              FUNC_SYNC: begin
                if (period_beat[BeatBits-1] || period_beat == '0) begin
                  kind <= KIND_BAD_PERIOD;
                  result_tag <= tag;
                  target_beat <= '0;
                  last <= 1'b1;
                  out_valid <= 1'b1;
                  state <= S_OUT;
                end else if (used >= CW'(TABLE_DEPTH)) begin
                  kind <= KIND_FULL;
                  result_tag <= tag;
                  target_beat <= '0;
                  last <= 1'b1;
                  out_valid <= 1'b1;
                  state <= S_OUT;
                end else begin
                  t_c <= cur_beat;
                  t_p <= period_beat;
                  t_f <= offset_beat;
                  t_g <= origin_beat;
                  t_start <= 1'b1;
                  state <= S_SYNC;
                end
              end
              FUNC_TICK: begin
                cur_beat <= position_beat;
                state <= S_TICK;
              end
              FUNC_RESCHED: begin
                cur_beat <= position_beat;
                state <= S_RES;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_SYNC: begin
          if (t_done) begin
            e_period[ui] <= per;
            e_offset[ui] <= off;
            e_origin[ui] <= org;
            e_target[ui] <= t_res;
            e_tag[ui] <= tg;
            used <= used + CW'(1);
            kind <= KIND_ACCEPTED;
            result_tag <= tg;
            target_beat <= t_res;
            last <= 1'b1;
            out_valid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_TICK: begin
          if (rd >= used) begin
            used <= wr;
            state <= S_IDLE;
          end else if (hit) begin
            kind <= KIND_FIRED;
            result_tag <= e_tag[ri];
            target_beat <= e_target[ri];
            fired <= fired + 5'd1;
            rd <= rd + CW'(1);
            state <= S_TICK_OUT;
          end else begin
            e_period[wi] <= e_period[ri];
            e_offset[wi] <= e_offset[ri];
            e_origin[wi] <= e_origin[ri];
            e_target[wi] <= e_target[ri];
            e_tag[wi] <= e_tag[ri];
            wr <= wr + CW'(1);
            rd <= rd + CW'(1);
          end
        end
        S_TICK_OUT: begin
          if (hit) begin
            last <= 1'b0;
            out_valid <= 1'b1;
            state <= S_OUT;
          end else if (rd >= used) begin
            last <= 1'b1;
            out_valid <= 1'b1;
            state <= S_OUT;
          end else begin
            e_period[wi] <= e_period[ri];
            e_offset[wi] <= e_offset[ri];
            e_origin[wi] <= e_origin[ri];
            e_target[wi] <= e_target[ri];
            e_tag[wi] <= e_tag[ri];
            wr <= wr + CW'(1);
            rd <= rd + CW'(1);
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (last) begin
              if (rd != '0) used <= wr;
              state <= S_IDLE;
            end else begin
              kind <= KIND_FIRED;
              result_tag <= e_tag[ri];
              target_beat <= e_target[ri];
              fired <= fired + 5'd1;
              rd <= rd + CW'(1);
              state <= S_TICK_OUT;
            end
          end
        end
        S_RES: begin
          if (rd >= used) begin
            state <= S_IDLE;
          end else begin
            t_c <= pos;
            t_p <= e_period[ri];
            t_f <= e_offset[ri];
            t_g <= e_origin[ri];
            t_start <= 1'b1;
            state <= S_RES_WAIT;
          end
        end
        S_RES_WAIT: begin
          if (t_done) begin
            e_target[ri] <= t_res;
            rd <= rd + CW'(1);
            state <= S_RES;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* hw/rtl/bses_checker.sv */
`include "beat_sync_event_scheduler_defines.svh"
module bses_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic [1:0] kind,
  input logic [47:0] target_beat,
  input logic last
);
  import bses_pkg::*;
  `BSES_ASSERT_IMPL(a_busy_out, out_valid, in_stall)
  `BSES_ASSERT_IMPL(a_reject_zero, out_valid && (kind == KIND_BAD_PERIOD || kind == KIND_FULL),
    target_beat == '0 && last)
  `BSES_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(target_beat))
  `BSES_ASSERT_IMPL(a_accept_last, out_valid && kind == KIND_ACCEPTED, last)
  `BSES_ASSERT_IMPL(a_accept_idle, in_valid && !in_stall, !out_valid)
endmodule

bind beat_sync_event_scheduler bses_checker u_bses_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .kind(kind), .target_beat(target_beat), .last(last)
);

/* dv/tb_beat_sync_event_scheduler.sv */
`default_nettype none

module tb_beat_sync_event_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  import bses_pkg::*;

  localparam int Depth = 16;
  localparam int FireMax = 16;
  localparam longint CycleLimit = 2000000;
  localparam int SettleCycles = 3000;
  localparam int HoldCycles = 3000;

  typedef struct {
    beat_t per;
    beat_t off;
    beat_t org;
    beat_t tgt;
    tag_t  tg;
  } slot_t;

  typedef struct {
    kind_t kd;
    tag_t  tg;
    beat_t tgt;
    logic  lst;
  } sched_res_t;

  typedef struct {
    func_t fn;
    beat_t pos;
    beat_t per;
    beat_t off;
    beat_t org;
    tag_t  tg;
    bit    chk;
    kind_t kd;
    beat_t tgt;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] func = FUNC_NONE;
  beat_t position_beat = '0;
  beat_t period_beat = '0;
  beat_t offset_beat = '0;
  beat_t origin_beat = '0;
  tag_t tag = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] kind;
  tag_t result_tag;
  beat_t target_beat;
  logic last;

  beat_sync_event_scheduler u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .position_beat(position_beat), .period_beat(period_beat),
    .offset_beat(offset_beat), .origin_beat(origin_beat), .tag(tag),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .result_tag(result_tag), .target_beat(target_beat), .last(last)
  );

  slot_t      pending_q[$];
  beat_t      now_beat;
  sched_res_t due_q[$];
  int         errors = 0;
  int         snd_idle_pct = 0;
  int         rcv_stall_pct = 0;
  bit         hold_req = 0;
  bit         holding = 0;
  longint     cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic beat_t rnd48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  function automatic beat_t target_of(longint c, longint p, longint f, longint g);
    longint r, nb;
    if (p <= 0) return '0;
    if (c % p == 0) return beat_t'(c);
    r = (c - g) % p;
    if (r < 0) r += p;
    nb = c - r + p + f;
    if (nb <= c) nb += ((c - nb) / p + 1) * p;
    if (nb < 0) nb = 0;
    if (nb > longint'(BeatMax)) nb = longint'(BeatMax);
    return beat_t'(nb);
  endfunction

  function automatic void add_due(kind_t kd, tag_t tg, beat_t tgt, logic lst);
    sched_res_t r;
    r.kd = kd;
    r.tg = tg;
    r.tgt = tgt;
    r.lst = lst;
    due_q.insert(due_q.size(), r);
  endfunction

  function automatic void schedule_item(func_t fn, beat_t pos, beat_t per, beat_t off,
                                        beat_t org, tag_t tg);
    slot_t s;
    slot_t keep_q[$];
    int k;
    k = 0;
    case (fn)
      FUNC_SYNC: begin
        if (per <= 0) begin
          add_due(KIND_BAD_PERIOD, tg, '0, 1'b1);
        end else if (pending_q.size() >= Depth) begin
          add_due(KIND_FULL, tg, '0, 1'b1);
        end else begin
          s.per = per;
          s.off = off;
          s.org = org;
          s.tg = tg;
          s.tgt = target_of(longint'(now_beat), longint'(per), longint'(off), longint'(org));
          pending_q.insert(pending_q.size(), s);
          add_due(KIND_ACCEPTED, tg, s.tgt, 1'b1);
        end
      end
      FUNC_TICK: begin
        now_beat = pos;
        foreach (pending_q[i]) begin
          if (k < FireMax && pos > pending_q[i].tgt) begin
            add_due(KIND_FIRED, pending_q[i].tg, pending_q[i].tgt, 1'b0);
            k++;
          end else begin
            keep_q.insert(keep_q.size(), pending_q[i]);
          end
        end
        pending_q = keep_q;
        if (k > 0) due_q[$].lst = 1'b1;
      end
      FUNC_RESCHED: begin
        foreach (pending_q[i])
          pending_q[i].tgt = target_of(longint'(pos), longint'(pending_q[i].per),
                                       longint'(pending_q[i].off),
                                       longint'(pending_q[i].org));
        now_beat = pos;
      end
      default: ;
    endcase
  endfunction

  task automatic send_request(func_t fn, beat_t pos, beat_t per, beat_t off, beat_t org,
                              tag_t tg);
    if (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    in_valid <= 1'b1;
    func <= fn;
    position_beat <= pos;
    period_beat <= per;
    offset_beat <= off;
    origin_beat <= org;
    tag <= tg;
    do @(posedge clk); while (in_stall);
    schedule_item(fn, pos, per, off, org, tg);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_q.size() != 0);
  endtask

  task automatic random_request();
    int sel;
    beat_t pos, per, off;
    longint lim;
    sel = $urandom_range(99);
    pos = '0;
    per = '0;
    off = '0;
    if (sel < 50) begin
      case ($urandom_range(9))
        0: per = ($urandom_range(1) != 0) ? beat_t'(0) : rnd48() | BeatMax + 1;
        1, 2: per = beat_t'(rnd48() >> 1) | beat_t'(1);
        default: per = beat_t'($urandom_range(1 << 20, 1));
      endcase
      if (per > 0 && per < (beat_t'(1) <<< 32)) begin
        lim = longint'(per) * 8;
        off = beat_t'(longint'({$urandom, $urandom} % (2 * lim + 1)) - lim);
      end else begin
        off = rnd48();
      end
      send_request(FUNC_SYNC, rnd48(), per, off, rnd48(), tag_t'($urandom));
    end else if (sel < 85) begin
      if ($urandom_range(9) == 0) pos = rnd48();
      else pos = now_beat + beat_t'($urandom_range(4 << 16));
      send_request(FUNC_TICK, pos, rnd48(), rnd48(), rnd48(), tag_t'($urandom));
    end else if (sel < 95) begin
      if ($urandom_range(3) == 0) pos = rnd48();
      else pos = now_beat + beat_t'($urandom_range(2 << 16));
      send_request(FUNC_RESCHED, pos, rnd48(), rnd48(), rnd48(), tag_t'($urandom));
    end else begin
      send_request(FUNC_NONE, rnd48(), rnd48(), rnd48(), rnd48(), tag_t'($urandom));
    end
  endtask

  always @(posedge clk) begin
    sched_res_t e;
    if (!rst && out_valid && !out_stall) begin
      if (due_q.size() == 0) begin
        $error("unexpected result kind %0d tag %h", kind, result_tag);
        errors++;
      end else begin
        e = due_q.pop_front();
        if (kind !== e.kd) begin
          $error("kind: expected %0d, actual %0d", e.kd, kind);
          errors++;
        end
        if (result_tag !== e.tg) begin
          $error("result_tag: expected %h, actual %h", e.tg, result_tag);
          errors++;
        end
        if (target_beat !== e.tgt) begin
          $error("target_beat: expected %h, actual %h", e.tgt, target_beat);
          errors++;
        end
        if (last !== e.lst) begin
          $error("last: expected %b, actual %b", e.lst, last);
          errors++;
        end
      end
    end
    out_stall <= holding || (rcv_stall_pct > 0 && $urandom_range(99) < rcv_stall_pct);
  end

  initial begin
    wait (hold_req);
    @(posedge clk);
    holding = 1'b1;
    repeat (HoldCycles) @(posedge clk);
    holding = 1'b0;
  end

  initial begin
    stim_row_t rows[11];
    sched_res_t exp_r;
    rows = '{
      '{FUNC_SYNC, '0, '0, '0, '0, 16'hFFFF, 1, KIND_BAD_PERIOD, '0},
      '{FUNC_SYNC, '0, BeatMax + 1, BeatMax, BeatMax + 1, 16'h0000, 1, KIND_BAD_PERIOD, '0},
      '{FUNC_SYNC, '0, 48'd1, '0, '0, 16'h5A5A, 1, KIND_ACCEPTED, '0},
      '{FUNC_TICK, '0, '0, '0, '0, '0, 0, KIND_FIRED, '0},
      '{FUNC_TICK, 48'd1, '0, '0, '0, '0, 1, KIND_FIRED, '0},
      '{FUNC_SYNC, '0, BeatMax, BeatMax + 1, BeatMax, 16'h0000, 0, KIND_ACCEPTED, '0},
      '{FUNC_SYNC, '0, 48'h4000_0000_0000, BeatMax, BeatMax + 1, 16'hA5A5, 1,
        KIND_ACCEPTED, BeatMax},
      '{FUNC_NONE, BeatMax, BeatMax, BeatMax, BeatMax, 16'hFFFF, 0, KIND_ACCEPTED, '0},
      '{FUNC_RESCHED, BeatMax, '0, '0, '0, '0, 0, KIND_ACCEPTED, '0},
      '{FUNC_RESCHED, BeatMax + 1, '0, '0, '0, '0, 0, KIND_ACCEPTED, '0},
      '{FUNC_TICK, BeatMax + 1, '0, '0, '0, '0, 0, KIND_ACCEPTED, '0}
    };
    now_beat = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      send_request(rows[i].fn, rows[i].pos, rows[i].per, rows[i].off, rows[i].org,
                   rows[i].tg);
      if (rows[i].chk) begin
        exp_r = due_q[$];
        if (exp_r.kd !== rows[i].kd || exp_r.tgt !== rows[i].tgt) begin
          $error("row %0d: table kind %0d target %h, predicted kind %0d target %h",
                 i, rows[i].kd, rows[i].tgt, exp_r.kd, exp_r.tgt);
          errors++;
        end
      end
    end
    for (int i = 0; i <= Depth; i++)
      send_request(FUNC_SYNC, '0, beat_t'(i + 1) <<< 16, beat_t'(i) <<< 12, rnd48(),
                   tag_t'(i));
    if (due_q[$].kd !== KIND_FULL) begin
      $error("kind: expected %0d, actual %0d", KIND_FULL, due_q[$].kd);
      errors++;
    end
    send_request(FUNC_TICK, BeatMax, '0, '0, '0, '0);
    drain();

    hold_req = 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 78; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 78; end
        default: begin snd_idle_pct = 25; rcv_stall_pct = 25; end
      endcase
      repeat (88) random_request();
      drain();
    end

    in_valid <= 1'b0;
    while (due_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (due_q.size() != 0) begin
      $error("%0d results never arrived", due_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
